@@ design/ssbm_pkg.sv @@
// Package for the stereo SAD block matcher: sizes, config register indexes and the cell control struct.
// No dependencies.
`timescale 1ns / 1ps
package ssbm_pkg;
	localparam int WINDOW_SIZE_D  = 7;
	localparam int SEARCH_RANGE_D = 56;
	localparam int MAX_WIDTH_D    = 1024;
	localparam int LINE_ROWS_D    = 8;
	localparam int SAD_W          = 24;
	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	// Control handed from the sequencer to every cell.
	typedef struct packed {
		logic clear;
		logic acc;
		logic [7:0] lpix;
	} ssbm_ctl_t;
endpackage

@@ design/ssbm_cell.sv @@
// One candidate cell: accumulates a SAD and passes its right pixel to the next cell.
// Depends on ssbm_pkg.
`timescale 1ns / 1ps
module ssbm_cell (
	input  logic clk,
	input  ssbm_pkg::ssbm_ctl_t ctl,
	input  logic [7:0] rpix_in,
	input  logic en_in,
	output logic [7:0] rpix_out,
	output logic [ssbm_pkg::SAD_W-1:0] sad
);
	import ssbm_pkg::*;
	logic [7:0] rpix_q;
	logic [SAD_W-1:0] sad_q;
	logic [7:0] diff;

	// Absolute difference of the shared left pixel and this cell's right pixel.
	assign diff = (ctl.lpix > rpix_in) ? ctl.lpix - rpix_in : rpix_in - ctl.lpix;

	// Shift the right pixel along and accumulate.
	always_ff @(posedge clk) begin
		rpix_q <= rpix_in;
		if (ctl.clear) begin
			sad_q <= '0;
		end else if (ctl.acc && en_in) begin
			sad_q <= sad_q + SAD_W'(diff);
		end
	end
	assign rpix_out = rpix_q;
	assign sad = sad_q;
endmodule

@@ design/stereo_sad_block_match_core.sv @@
// Stereo SAD block matcher, top level with line stores and sequencer.
// One request at a time: input stalls while the sequencer is busy, until the result is loaded
// into the output register, which out_stall can hold off; a request with no result returns to
// idle from the init step. Reset (arst_n low) clears positions, flags and control state and sets
// the frame size to 640x480; read data, cell sums and stores stay undefined.
`timescale 1ns / 1ps
module stereo_sad_block_match_core #(
	parameter int WINDOW_SIZE  = ssbm_pkg::WINDOW_SIZE_D,
	parameter int SEARCH_RANGE = ssbm_pkg::SEARCH_RANGE_D,
	parameter int MAX_WIDTH    = ssbm_pkg::MAX_WIDTH_D,
	parameter int LINE_ROWS    = ssbm_pkg::LINE_ROWS_D
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [7:0] left_gray,
	input  logic [7:0] right_gray,
	input  logic start_of_frame,
	input  logic is_blank,
	output logic out_valid,
	input  logic out_stall,
	output logic [5:0] disparity,
	output logic [9:0] out_row,
	output logic [9:0] out_col,
	output logic last_of_frame,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_index,
	input  logic [10:0] cfg_data
);
	import ssbm_pkg::*;
	localparam int NC = 2 * SEARCH_RANGE;
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(LINE_ROWS);
	localparam int AW = CW + RW;
	localparam int DEPTH = LINE_ROWS * MAX_WIDTH;
	localparam int KW = $clog2(NC + WINDOW_SIZE + 4);
	localparam int NW = $clog2(NC + 1);
	localparam int HI_W = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
	localparam logic [2:0] ST_IDLE = 3'd0, ST_INIT = 3'd1, ST_RUN = 3'd2,
		ST_PICK = 3'd3, ST_OUT = 3'd4;

	logic [10:0] fw_q, fh_q;
	logic [10:0] w, h;
	logic [10:0] in_row_q, in_col_q, out_row_q, out_col_q;
	logic in_done_q, out_done_q;
	logic [2:0] st_q;
	logic [7:0] lmem [DEPTH];
	logic [7:0] rmem [DEPTH];
	logic [7:0] lrd_s1, rrd_s1;

	// Effective frame size after clamping.
	always_comb begin
		w = fw_q;
		if (w < 11'd8) w = 11'd8;
		if (w > 11'(HI_W)) w = 11'(HI_W);
		h = fh_q;
		if (h < 11'd8) h = 11'd8;
		if (h > 11'd1024) h = 11'd1024;
	end

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= 11'd640;
			fh_q <= 11'd480;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_WIDTH:  fw_q <= cfg_data;
				CFG_HEIGHT: fh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Match window geometry for the pending output pixel.
	logic [10:0] rend, cend, wcols, lo, hi_c, hi_lim;
	always_comb begin
		rend = (out_row_q + 11'(WINDOW_SIZE) < h) ? out_row_q + 11'(WINDOW_SIZE) : h;
		cend = (out_col_q + 11'(WINDOW_SIZE) < w) ? out_col_q + 11'(WINDOW_SIZE) : w;
		wcols = cend - out_col_q;
		lo = (out_col_q > 11'(SEARCH_RANGE)) ? out_col_q - 11'(SEARCH_RANGE) : 11'd0;
		hi_lim = w - wcols;
		hi_c = out_col_q + 11'(SEARCH_RANGE) - 11'd1;
		if (hi_c > hi_lim) hi_c = hi_lim;
	end

	// Sequencer counters: row i of the window, step k along the right stream.
	logic [10:0] wi_q;
	logic [KW-1:0] k_q;
	logic [NW-1:0] pick_q;
	logic [SAD_W-1:0] best_q;
	logic [10:0] bcol_q;
	logic [NC-1:0] en_q;
	ssbm_ctl_t ctl;
	logic acc_s1;

	// Read addresses: left at (wi, col+j) with j = k - (NC-1), right at (wi, lo+k).
	logic [10:0] rcol, lcol;
	logic [KW-1:0] kj;
	logic lvalid;
	logic [AW-1:0] raddr, laddr;
	always_comb begin
		rcol = lo + 11'(k_q);
		kj = k_q - KW'(NC - 1);
		lvalid = (k_q >= KW'(NC - 1)) && (11'(kj) < wcols);
		lcol = out_col_q + 11'(kj);
		raddr = {RW'(wi_q % 11'(LINE_ROWS)), CW'(rcol)};
		laddr = {RW'(wi_q % 11'(LINE_ROWS)), CW'(lcol)};
	end

	logic accept_in, wr_en;
	assign accept_in = in_valid && !in_stall;
	assign wr_en = accept_in && !is_blank && (start_of_frame || !in_done_q);
	logic [AW-1:0] waddr;
	assign waddr = start_of_frame ? '0 :
		{RW'(in_row_q % 11'(LINE_ROWS)), CW'(in_col_q)};

	// Line stores, one write and one registered read each.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			lmem[waddr] <= left_gray;
			rmem[waddr] <= right_gray;
		end
		lrd_s1 <= lmem[laddr];
		rrd_s1 <= rmem[raddr];
		acc_s1 <= (st_q == ST_RUN) && lvalid;
	end

	// Chain of cells. Right pixels enter at rp[0] and move one cell per cycle,
	// while the left pixel is shared by all cells.
	assign ctl.clear = (st_q == ST_INIT);
	assign ctl.acc = acc_s1;
	assign ctl.lpix = lrd_s1;
	logic [7:0] rp [NC+1];
	logic [SAD_W-1:0] sads [NC];
	assign rp[0] = rrd_s1;
	genvar g;
	generate
		for (g = 0; g < NC; g++) begin : g_cell
			ssbm_cell u_cell (.clk(clk), .ctl(ctl), .rpix_in(rp[g]), .en_in(en_q[g]),
				.rpix_out(rp[g+1]), .sad(sads[g]));
		end
	endgenerate
	// Cell g sees right pixel lo + (k-g) when left column k-(NC-1) arrives,
	// so cell g holds candidate lo + NC-1-g.

	logic need_ok;
	logic [10:0] need;
	always_comb begin
		need = out_row_q + 11'(WINDOW_SIZE - 1);
		if (need > h - 11'd1) need = h - 11'd1;
		need_ok = in_done_q || (in_row_q > need);
	end

	logic [10:0] cand_pick;
	assign cand_pick = lo + 11'(NC - 1) - 11'(pick_q);
	logic [10:0] dval;
	assign dval = (out_col_q > bcol_q) ? out_col_q - bcol_q : 11'd0;
	// The result register parts the output from the input side.
	assign in_stall = (st_q != ST_IDLE);
	logic out_load;
	assign out_load = (st_q == ST_OUT) && (!out_valid || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			in_row_q <= '0; in_col_q <= '0; out_row_q <= '0; out_col_q <= '0;
			in_done_q <= 1'b0; out_done_q <= 1'b0;
			out_valid <= 1'b0;
			wi_q <= '0; k_q <= '0; pick_q <= '0; en_q <= '0;
			best_q <= '0; bcol_q <= '0;
			disparity <= '0; out_row <= '0; out_col <= '0; last_of_frame <= 1'b0;
		end else begin
			// Result register: loaded by the output step, cleared once taken.
			if (out_load) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (accept_in) begin
						if (!is_blank) begin
							if (start_of_frame) begin
								in_row_q <= '0;
								in_col_q <= 11'd1;
								out_row_q <= '0; out_col_q <= '0;
								in_done_q <= 1'b0; out_done_q <= 1'b0;
							end else if (!in_done_q) begin
								if (in_col_q + 11'd1 >= w) begin
									in_col_q <= '0;
									in_row_q <= in_row_q + 11'd1;
									if (in_row_q + 11'd1 >= h) in_done_q <= 1'b1;
								end else begin
									in_col_q <= in_col_q + 11'd1;
								end
							end
						end
						st_q <= ST_INIT;
					end
				end
				ST_INIT: begin
					if (out_done_q) begin
						st_q <= ST_IDLE;
					end else if (out_row_q >= h || out_col_q >= w) begin
						out_done_q <= 1'b1;
						st_q <= ST_IDLE;
					end else if (!need_ok) begin
						st_q <= ST_IDLE;
					end else begin
						wi_q <= out_row_q;
						k_q <= '0;
						for (int n = 0; n < NC; n++)
							en_q[n] <= (lo + 11'(NC - 1 - n) <= hi_c);
						st_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (k_q == KW'(NC - 1) + KW'(WINDOW_SIZE) + KW'(2)) begin
						k_q <= '0;
						if (wi_q + 11'd1 >= rend) begin
							pick_q <= NW'(NC - 1);
							best_q <= '1;
							bcol_q <= lo;
							st_q <= ST_PICK;
						end else begin
							wi_q <= wi_q + 11'd1;
						end
					end else begin
						k_q <= k_q + KW'(1);
					end
				end
				ST_PICK: begin
					// Walk candidates from lowest column upward; strict less keeps first.
					if (en_q[pick_q] && (sads[pick_q] < best_q ||
						(best_q == '1 && cand_pick == lo))) begin
						best_q <= sads[pick_q];
						bcol_q <= cand_pick;
					end
					if (pick_q == '0) st_q <= ST_OUT;
					else pick_q <= pick_q - NW'(1);
				end
				ST_OUT: begin
					if (out_load) begin
						disparity <= (dval > 11'd63) ? 6'd63 : dval[5:0];
						out_row <= out_row_q[9:0];
						out_col <= out_col_q[9:0];
						last_of_frame <= (out_row_q == h - 11'd1) && (out_col_q == w - 11'd1);
						if ((out_row_q == h - 11'd1) && (out_col_q == w - 11'd1))
							out_done_q <= 1'b1;
						if (out_col_q + 11'd1 >= w) begin
							out_col_q <= '0;
							out_row_q <= out_row_q + 11'd1;
						end else begin
							out_col_q <= out_col_q + 11'd1;
						end
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	// No input is taken while a match is in progress.
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_RUN) |-> in_stall) else $error("input taken while busy");
	// A result appears only from the output step.
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(st_q) == ST_OUT) else $error("stray result");
	// The output position never passes the input position unless input is done.
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_RUN) |-> (in_done_q || in_row_q > out_row_q))
		else $error("match before rows arrived");
`endif
endmodule
